@@ rtl/mbps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Masked byte pattern search package
// Shared constants, codes and transaction types of the search core.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int unsigned MAX_PATTERN = 64;
  localparam int unsigned PosW        = 32;

  localparam logic [1:0] CMD_APPEND  = 2'd0;
  localparam logic [1:0] CMD_SCAN    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_value;
    logic       care;
    logic       last_image;
  } in_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [PosW-1:0] match_offset;
  } out_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic clear_scan;
    logic clear_pattern;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/mbps_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Masked byte pattern search cell
// Holds one pattern position and its partial match bit of the shift-and chain.
// ----------------------------------------------------------------------------
module mbps_cell
  import mbps_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       care_i,
  input  wire logic       prev_used_i,
  input  wire logic       prev_partial_i,
  input  wire logic       next_used_i,
  output logic            used_o,
  output logic            partial_o,
  output logic            hit_o
);

  logic [7:0] pat_q;
  logic       care_q;
  logic       used_q,    used_d;
  logic       partial_q, partial_d;
  logic       slot;
  logic       eq;
  logic       step;

  assign slot = prev_used_i && !used_q;
  assign eq   = !care_q || (pat_q == byte_i);
  assign step = prev_partial_i && eq;

  always_comb begin
    used_d = used_q;
    if (ctrl_i.clear_pattern) begin
      used_d = 1'b0;
    end else if (ctrl_i.load && slot) begin
      used_d = 1'b1;
    end
  end

  always_comb begin
    partial_d = partial_q;
    if (ctrl_i.clear_scan) begin
      partial_d = 1'b0;
    end else if (ctrl_i.scan && used_q) begin
      partial_d = step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= 1'b0;
      partial_q <= 1'b0;
    end else begin
      used_q    <= used_d;
      partial_q <= partial_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && slot) begin
      pat_q  <= byte_i;
      care_q <= care_i;
    end
  end

  assign used_o    = used_q;
  assign partial_o = partial_q;
  assign hit_o     = used_q && !next_used_i && step;

endmodule

`default_nettype wire

@@ rtl/masked_byte_pattern_search_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Masked byte pattern search core
// Loads a wildcard byte pattern into a row of cells and scans image bytes
// through it, reporting the offset of the first full match.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the skid stage is empty; every
// cell compares its pattern byte against the image byte in the same cycle and
// passes its bit to the next cell. A two-entry output register keeps input
// accepted while one result waits.
// Reset clears pattern length, scan state and the valid flags of the output
// stages; pattern bytes and output data are held without reset.
module masked_byte_pattern_search_core
  import mbps_pkg::*;
#(
  parameter int unsigned MaxPattern = MAX_PATTERN
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  localparam int unsigned LenW = $clog2(MaxPattern + 1);

  logic                  in_fire;
  logic                  out_fire;
  logic                  is_append;
  logic                  is_scan;
  logic                  is_restart;
  logic                  len_zero;
  logic                  found;
  cell_ctrl_t            ctrl;
  out_t                  res;

  logic [LenW-1:0]       len_q,  len_d;
  logic [PosW-1:0]       pos_q,  pos_d;
  logic                  done_q, done_d;

  logic [MaxPattern-1:0] used;
  logic [MaxPattern-1:0] partial;
  logic [MaxPattern-1:0] hit;

  out_t                  out_q,  skid_q;
  logic                  out_valid_q, skid_valid_q;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  assign is_append  = in_fire && (in_data_i.command == CMD_APPEND);
  assign is_scan    = in_fire && (in_data_i.command == CMD_SCAN);
  assign is_restart = in_fire && (in_data_i.command == CMD_RESTART);
  assign len_zero   = (len_q == '0);

  assign ctrl.load          = is_append;
  assign ctrl.scan          = is_scan && !len_zero && !done_q;
  assign ctrl.clear_scan    = is_restart || (is_scan && in_data_i.last_image);
  assign ctrl.clear_pattern = is_restart;

  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    logic prev_used;
    logic prev_partial;
    logic next_used;

    if (k == 0) begin : g_head
      assign prev_used    = 1'b1;
      assign prev_partial = 1'b1;
    end else begin : g_body
      assign prev_used    = used[k-1];
      assign prev_partial = partial[k-1];
    end

    if (k == MaxPattern - 1) begin : g_tail
      assign next_used = 1'b0;
    end else begin : g_link
      assign next_used = used[k+1];
    end

    mbps_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .byte_i         (in_data_i.byte_value),
      .care_i         (in_data_i.care),
      .prev_used_i    (prev_used),
      .prev_partial_i (prev_partial),
      .next_used_i    (next_used),
      .used_o         (used[k]),
      .partial_o      (partial[k]),
      .hit_o          (hit[k])
    );
  end

  assign found = |hit;

  always_comb begin
    res.status       = ST_NONE;
    res.match_offset = '0;
    if (in_data_i.command == CMD_SCAN) begin
      if (len_zero) begin
        res.status = ST_EMPTY;
      end else if (!done_q) begin
        if (found) begin
          res.status       = ST_FOUND;
          res.match_offset = pos_q - PosW'(len_q) + PosW'(1);
        end else if (in_data_i.last_image) begin
          res.status = ST_NOT_FOUND;
        end
      end
    end
  end

  always_comb begin
    len_d  = len_q;
    pos_d  = pos_q;
    done_d = done_q;
    if (is_restart) begin
      len_d = '0;
    end else if (is_append && (len_q != LenW'(MaxPattern))) begin
      len_d = len_q + LenW'(1);
    end
    if (ctrl.scan && found) begin
      done_d = 1'b1;
    end
    if (is_scan) begin
      pos_d = pos_q + PosW'(1);
    end
    if (ctrl.clear_scan) begin
      pos_d  = '0;
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      pos_q  <= '0;
      done_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      pos_q  <= pos_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_fire) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_fire;
        end
      end else if (in_fire) begin
        if (!out_valid_q) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      if (!out_valid_q) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the output stage is empty");

  a_single_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit))
    else $error("more than one cell reports a full match");

  a_len_tracks_cells : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_zero == !used[0])
    else $error("pattern length disagrees with the occupied cells");

  a_found_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && is_scan) |-> (res.status == ST_NONE))
    else $error("second match reported within one scan");

endmodule

`default_nettype wire
